// ----- design/glob_wildcard_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher assertion macros
// Shared concurrent assertion forms, clocked on aclk, idle during reset.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// same-cycle implication
`define GWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// gwm_pkg
// Types and constants shared by the glob wildcard matcher modules.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_ANY     = 2'd1;
    localparam logic [1:0] KIND_STAR    = 2'd2;

    localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
    localparam logic [7:0] CHAR_STAR      = 8'h2A;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_SUBJECT = 1'b1;

    localparam logic RESULT_STATUS  = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_value;
        logic       carries_char;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic result_kind;
        logic pattern_ok;
        logic matched;
    } out_item_t;

    // broadcast controls for the cell row
    typedef struct packed {
        logic [1:0] wr_kind;
        logic [7:0] wr_byte;
        logic [7:0] subj_byte;
        logic       seed_start;
        logic       start_load;
        logic       act_load;
        logic       act_start;
    } cell_ctrl_t;

endpackage

// ----- design/gwm_cell.sv -----
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: element store, active bit, start bit, star closure.
// ----------------------------------------------------------------------------
module gwm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  gwm_pkg::cell_ctrl_t ctrl,
    input  logic                head,
    input  logic                wr_en,
    input  logic                in_use_cur,
    input  logic                in_use_next,
    input  logic                step_in,
    input  logic                close_in,
    output logic                step_out,
    output logic                close_out,
    output logic                close_val,
    output logic                active
);

    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       active_reg;
    logic       active_next;
    logic       start_reg;
    logic       start_next;
    logic       star_cur;
    logic       star_nxt;
    logic       seed;

    assign kind_next = wr_en ? ctrl.wr_kind : kind_reg;
    assign byte_next = wr_en ? ctrl.wr_byte : byte_reg;

    assign star_cur = in_use_cur & (kind_reg == gwm_pkg::KIND_STAR);
    assign star_nxt = in_use_next & (kind_next == gwm_pkg::KIND_STAR);

    assign step_out = active_reg & in_use_cur & (kind_reg != gwm_pkg::KIND_STAR) &
                      ((kind_reg == gwm_pkg::KIND_ANY) | (byte_reg == ctrl.subj_byte));

    assign seed      = ctrl.seed_start ? head : ((active_reg & star_cur) | step_in);
    assign close_val = seed | close_in;
    assign close_out = close_val & star_nxt;
    assign active    = active_reg;

    always_comb begin
        if (ctrl.act_start) begin
            active_next = start_reg;
        end else if (ctrl.act_load) begin
            active_next = close_val;
        end else begin
            active_next = active_reg;
        end
        start_next = ctrl.start_load ? close_val : start_reg;
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= head;
            start_reg  <= head;
        end else begin
            active_reg <= active_next;
            start_reg  <= start_next;
        end
    end

endmodule

// ----- design/glob_wildcard_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Result: registered, valid the cycle after its accepted last item.
// One item per cycle while s_ready; a subject byte updates the whole row.
// Reset: empty pattern loaded, only the start position active.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
    parameter int PATTERN_MAX = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gwm_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output gwm_pkg::out_item_t m_item
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int NC = PATTERN_MAX + 1;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               esc_reg;
    logic               esc_next;
    logic               pat_ok_reg;
    logic               pat_ok_next;
    logic               closed_reg;
    logic               closed_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    gwm_pkg::out_item_t m_item_reg;
    gwm_pkg::out_item_t m_item_next;

    logic          in_acc;
    logic          is_pat;
    logic          fresh;
    logic [CW-1:0] cnt_eff;
    logic          esc_eff;
    logic          ok_eff;
    logic          is_bs;
    logic          push;
    logic          esc_set;
    logic          esc_new;
    logic          full;
    logic          do_write;
    logic [CW-1:0] count_new;
    logic [CW-1:0] count_use;
    logic          ok_new;
    logic          pat_go;
    logic          subj_go;
    logic          pat_end;
    logic          subj_end;
    logic          end_hit;
    logic [1:0]    wr_kind;

    gwm_pkg::cell_ctrl_t ctrl;

    logic [NC:0]   step_vec;
    logic [NC:0]   close_chain;
    logic [NC-1:0] close_vec;
    logic [NC-1:0] act_vec;

    assign in_acc  = s_valid & s_ready;
    assign s_ready = !m_valid_reg | m_ready;
    assign is_pat  = s_item.opcode == gwm_pkg::OP_PATTERN;
    assign fresh   = is_pat & closed_reg;
    assign cnt_eff = fresh ? '0 : count_reg;
    assign esc_eff = !fresh & esc_reg;
    assign ok_eff  = fresh | pat_ok_reg;
    assign is_bs   = s_item.char_value == gwm_pkg::CHAR_BACKSLASH;

    assign push      = s_item.carries_char & (esc_eff | !is_bs);
    assign esc_set   = s_item.carries_char & !esc_eff & is_bs;
    assign esc_new   = esc_set | (esc_eff & !s_item.carries_char);
    assign full      = cnt_eff == CW'(PATTERN_MAX);
    assign do_write  = push & !full;
    assign count_new = cnt_eff + CW'(do_write);
    assign ok_new    = ok_eff & !(push & full) & !(s_item.last & esc_new);

    assign pat_go   = in_acc & is_pat;
    assign subj_go  = in_acc & !is_pat & closed_reg;
    assign pat_end  = pat_go & s_item.last;
    assign subj_end = subj_go & s_item.last;
    assign count_use = pat_go ? count_new : count_reg;

    always_comb begin
        if (esc_eff) begin
            wr_kind = gwm_pkg::KIND_LITERAL;
        end else if (s_item.char_value == gwm_pkg::CHAR_QUESTION) begin
            wr_kind = gwm_pkg::KIND_ANY;
        end else if (s_item.char_value == gwm_pkg::CHAR_STAR) begin
            wr_kind = gwm_pkg::KIND_STAR;
        end else begin
            wr_kind = gwm_pkg::KIND_LITERAL;
        end
    end

    always_comb begin
        ctrl.wr_kind    = wr_kind;
        ctrl.wr_byte    = s_item.char_value;
        ctrl.subj_byte  = s_item.char_value;
        ctrl.seed_start = is_pat;
        ctrl.start_load = pat_end;
        ctrl.act_load   = pat_end | (subj_go & s_item.carries_char & !s_item.last);
        ctrl.act_start  = subj_end;
    end

    assign step_vec[0]    = 1'b0;
    assign close_chain[0] = 1'b0;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        localparam logic [CW-1:0] IDX  = CW'(i);
        localparam logic          HEAD = (i == 0);
        gwm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .head        (HEAD),
            .wr_en       (pat_go & do_write & (cnt_eff == IDX)),
            .in_use_cur  (IDX < count_reg),
            .in_use_next (IDX < count_use),
            .step_in     (step_vec[i]),
            .close_in    (close_chain[i]),
            .step_out    (step_vec[i+1]),
            .close_out   (close_chain[i+1]),
            .close_val   (close_vec[i]),
            .active      (act_vec[i])
        );
    end

    assign end_hit = s_item.carries_char ? close_vec[count_reg] : act_vec[count_reg];

    always_comb begin
        count_next  = count_reg;
        esc_next    = esc_reg;
        pat_ok_next = pat_ok_reg;
        closed_next = closed_reg;
        if (pat_go) begin
            count_next  = count_new;
            esc_next    = !s_item.last & esc_new;
            pat_ok_next = ok_new;
            closed_next = s_item.last;
        end

        m_item_next.result_kind = is_pat ? gwm_pkg::RESULT_STATUS : gwm_pkg::RESULT_VERDICT;
        m_item_next.pattern_ok  = is_pat ? ok_new : pat_ok_reg;
        m_item_next.matched     = !is_pat & pat_ok_reg & end_hit;

        if (pat_end | subj_end) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            esc_reg     <= 1'b0;
            pat_ok_reg  <= 1'b1;
            closed_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            esc_reg     <= esc_next;
            pat_ok_reg  <= pat_ok_next;
            closed_reg  <= closed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pat_end | subj_end) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- design/gwm_checker.sv -----
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks of the glob wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_macros.svh"

module gwm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input gwm_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input gwm_pkg::out_item_t m_item
);

    `GWM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result transaction dropped or changed while stalled")
    `GWM_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "input stalled with empty output")
    `GWM_ASSERT_NEXT(a_status_follows, s_valid && s_ready && s_item.opcode == gwm_pkg::OP_PATTERN && s_item.last, m_valid && m_item.result_kind == gwm_pkg::RESULT_STATUS, "no status after pattern end")
    `GWM_ASSERT_NOW(a_status_no_match, m_valid && m_item.result_kind == gwm_pkg::RESULT_STATUS, !m_item.matched, "status transaction flags a match")
    `GWM_ASSERT_NOW(a_match_needs_ok, m_valid && m_item.matched, m_item.pattern_ok, "match reported for invalid pattern")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ----- sim/glob_wildcard_matcher_tb.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_tb
// Loads glob patterns and streams subjects through the matcher: directed corner
// cases first, then random pattern/subject sequences with literal, ? and * elements
// and subjects mostly derived from them. A scoreboard predicts load status and
// match verdicts and checks every result transaction in order.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_tb;

    localparam int PATTERN_MAX = 32;

    typedef logic [7:0] bytes_t [$];

    class match_scoreboard;
        logic [9:0]          elems [PATTERN_MAX];
        int                  elem_cnt;
        bit                  esc_pending;
        bit                  pat_ok;
        bit                  load_done;
        bit [PATTERN_MAX:0]  act_set;
        gwm_pkg::out_item_t  expected_q [$];
        int                  errors;

        function new();
            elem_cnt    = 0;
            esc_pending = 1'b0;
            pat_ok      = 1'b1;
            load_done   = 1'b1;
            errors      = 0;
            act_set     = close_stars((PATTERN_MAX+1)'(1));
        endfunction

        function bit [PATTERN_MAX:0] close_stars(bit [PATTERN_MAX:0] s);
            for (int i = 0; i < elem_cnt; i++) begin
                if (s[i] && elems[i][9:8] == gwm_pkg::KIND_STAR) s[i+1] = 1'b1;
            end
            return s;
        endfunction

        function bit [PATTERN_MAX:0] step_set(bit [PATTERN_MAX:0] s, logic [7:0] c);
            bit [PATTERN_MAX:0] nx;
            nx = '0;
            for (int i = 0; i < elem_cnt; i++) begin
                if (s[i]) begin
                    if (elems[i][9:8] == gwm_pkg::KIND_STAR) nx[i] = 1'b1;
                    else if (elems[i][9:8] == gwm_pkg::KIND_ANY || elems[i][7:0] == c)
                        nx[i+1] = 1'b1;
                end
            end
            return close_stars(nx);
        endfunction

        function void add_elem(logic [1:0] kind, logic [7:0] c);
            if (elem_cnt >= PATTERN_MAX) begin
                pat_ok = 1'b0;
            end else begin
                elems[elem_cnt] = {kind, c};
                elem_cnt++;
            end
        endfunction

        function void note_input(gwm_pkg::in_item_t it);
            gwm_pkg::out_item_t r;
            if (it.opcode == gwm_pkg::OP_PATTERN) begin
                if (load_done) begin
                    elem_cnt    = 0;
                    esc_pending = 1'b0;
                    pat_ok      = 1'b1;
                    load_done   = 1'b0;
                end
                if (it.carries_char) begin
                    if (esc_pending) begin
                        add_elem(gwm_pkg::KIND_LITERAL, it.char_value);
                        esc_pending = 1'b0;
                    end else if (it.char_value == gwm_pkg::CHAR_BACKSLASH) begin
                        esc_pending = 1'b1;
                    end else if (it.char_value == gwm_pkg::CHAR_QUESTION) begin
                        add_elem(gwm_pkg::KIND_ANY, 8'h00);
                    end else if (it.char_value == gwm_pkg::CHAR_STAR) begin
                        add_elem(gwm_pkg::KIND_STAR, 8'h00);
                    end else begin
                        add_elem(gwm_pkg::KIND_LITERAL, it.char_value);
                    end
                end
                if (it.last) begin
                    if (esc_pending) pat_ok = 1'b0;
                    esc_pending   = 1'b0;
                    load_done     = 1'b1;
                    act_set       = close_stars((PATTERN_MAX+1)'(1));
                    r.result_kind = gwm_pkg::RESULT_STATUS;
                    r.pattern_ok  = pat_ok;
                    r.matched     = 1'b0;
                    expected_q.push_back(r);
                end
            end else if (load_done) begin
                if (it.carries_char) act_set = step_set(act_set, it.char_value);
                if (it.last) begin
                    r.result_kind = gwm_pkg::RESULT_VERDICT;
                    r.pattern_ok  = pat_ok;
                    r.matched     = pat_ok && act_set[elem_cnt];
                    expected_q.push_back(r);
                    act_set = close_stars((PATTERN_MAX+1)'(1));
                end
            end
        endfunction

        function void report(string what, gwm_pkg::out_item_t want, gwm_pkg::out_item_t got);
            errors++;
            if (errors <= 10)
                $display("%0t %s: want kind=%0b ok=%0b matched=%0b, got kind=%0b ok=%0b matched=%0b",
                         $time, what, want.result_kind, want.pattern_ok, want.matched,
                         got.result_kind, got.pattern_ok, got.matched);
        endfunction

        function void check_result(gwm_pkg::out_item_t got);
            gwm_pkg::out_item_t want;
            if (expected_q.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind || got.pattern_ok !== want.pattern_ok ||
                got.matched !== want.matched)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    gwm_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    gwm_pkg::out_item_t m_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    match_scoreboard sb = new();

    glob_wildcard_matcher #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic gwm_pkg::in_item_t txn(logic op, logic [7:0] c, logic has, logic lst);
        gwm_pkg::in_item_t it;
        it.opcode       = op;
        it.char_value   = c;
        it.carries_char = has;
        it.last         = lst;
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 8'h61 + 8'($urandom_range(2));
            6: begin
                case ($urandom_range(2))
                    0: return gwm_pkg::CHAR_QUESTION;
                    1: return gwm_pkg::CHAR_STAR;
                    default: return gwm_pkg::CHAR_BACKSLASH;
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input gwm_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_stream(input logic op, input bytes_t data);
        bit split_end;
        split_end = (data.size() == 0) || ($urandom_range(4) == 0);
        foreach (data[i]) begin
            if ($urandom_range(19) == 0)
                send_item(txn(op, 8'($urandom_range(255)), 1'b0, 1'b0));
            // subject traffic while the pattern is still open is dropped
            if (op == gwm_pkg::OP_PATTERN && i > 0 && $urandom_range(19) == 0)
                send_item(txn(gwm_pkg::OP_SUBJECT, 8'($urandom_range(255)),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
            send_item(txn(op, data[i], 1'b1, !split_end && i == data.size() - 1));
        end
        if (split_end) send_item(txn(op, 8'($urandom_range(255)), 1'b0, 1'b1));
    endtask

    task automatic run_sequence();
        logic [9:0] elem_q [$];
        bytes_t     pat;
        bytes_t     subj;
        logic [7:0] c;
        int         n;
        n = ($urandom_range(14) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: elem_q.push_back({gwm_pkg::KIND_ANY, 8'h00});
                2, 3: elem_q.push_back({gwm_pkg::KIND_STAR, 8'h00});
                default: elem_q.push_back({gwm_pkg::KIND_LITERAL, pick_char()});
            endcase
        end
        foreach (elem_q[i]) begin
            c = elem_q[i][7:0];
            case (elem_q[i][9:8])
                gwm_pkg::KIND_ANY: pat.push_back(gwm_pkg::CHAR_QUESTION);
                gwm_pkg::KIND_STAR: pat.push_back(gwm_pkg::CHAR_STAR);
                default: begin
                    if (c inside {gwm_pkg::CHAR_QUESTION, gwm_pkg::CHAR_STAR,
                                  gwm_pkg::CHAR_BACKSLASH} || $urandom_range(9) == 0)
                        pat.push_back(gwm_pkg::CHAR_BACKSLASH);
                    pat.push_back(c);
                end
            endcase
        end
        if ($urandom_range(19) == 0) pat.push_back(gwm_pkg::CHAR_BACKSLASH);
        send_stream(gwm_pkg::OP_PATTERN, pat);
        repeat ($urandom_range(1, 4)) begin
            subj.delete();
            if ($urandom_range(9) < 6) begin
                foreach (elem_q[i]) begin
                    case (elem_q[i][9:8])
                        gwm_pkg::KIND_ANY: subj.push_back(pick_char());
                        gwm_pkg::KIND_STAR: repeat ($urandom_range(3)) subj.push_back(pick_char());
                        default: subj.push_back(elem_q[i][7:0]);
                    endcase
                end
                if (subj.size() > 0 && $urandom_range(4) == 0)
                    subj[$urandom_range(subj.size() - 1)] = pick_char();
            end else begin
                repeat ($urandom_range(8)) subj.push_back(pick_char());
            end
            send_stream(gwm_pkg::OP_SUBJECT, subj);
        end
    endtask

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pattern after reset
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h00, 1'b0, 1'b1));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h61, 1'b1, 1'b1));
        // a ? * \*
        send_item(txn(gwm_pkg::OP_PATTERN, 8'h61, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_QUESTION, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_STAR, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_BACKSLASH, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_STAR, 1'b1, 1'b1));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h61, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'hFF, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h78, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h79, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_SUBJECT, gwm_pkg::CHAR_STAR, 1'b1, 1'b1));
        // trailing backslash, subject during open load
        send_item(txn(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_BACKSLASH, 1'b1, 1'b0));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h7A, 1'b1, 1'b1));
        send_item(txn(gwm_pkg::OP_PATTERN, 8'h00, 1'b0, 1'b1));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h7A, 1'b1, 1'b1));
        // literal zero byte
        send_item(txn(gwm_pkg::OP_PATTERN, 8'h00, 1'b1, 1'b1));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'hFF, 1'b0, 1'b0));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h00, 1'b1, 1'b1));
        send_item(txn(gwm_pkg::OP_PATTERN, 8'hFF, 1'b1, 1'b1));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'hFE, 1'b1, 1'b1));
        // lone star against empty subject
        send_item(txn(gwm_pkg::OP_PATTERN, gwm_pkg::CHAR_STAR, 1'b1, 1'b1));
        send_item(txn(gwm_pkg::OP_SUBJECT, 8'h00, 1'b0, 1'b1));

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            while (items_sent < 25 + 400 * (p + 1)) run_sequence();
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/gwm_pkg.sv
design/gwm_cell.sv
design/glob_wildcard_matcher.sv
design/gwm_checker.sv
sim/glob_wildcard_matcher_tb.sv
